// ===== src/rrfp_pkg.sv =====
package rrfp_pkg;

	// Number of cells in the chain. Element k lives in cell k % NCELLS at row k / NCELLS.
	localparam int NCELLS = 4;
	localparam int LANE_W = 2;

	// Width of the index fields of a word.
	localparam int IDX_W = 10;

	// A range holds at most 2**IDX_W elements, so a count needs one bit more.
	localparam int CNT_W = IDX_W + 1;

	localparam int DEPTH_DEF = 1024;
	localparam int VALUE_BITS_DEF = 16;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Control part of the token that travels down the chain.
	typedef struct packed {
		logic             valid;
		logic             scan;
		logic             last;
		logic [CNT_W-1:0] count;
	} tok_t;

	// Write strobe shared by all cells.
	typedef struct packed {
		logic              en;
		logic [LANE_W-1:0] lane;
	} wr_t;

endpackage

// ===== src/rrfp_cell.sv =====
module rrfp_cell #(
	parameter int VALUE_BITS = 16,
	parameter int ROWS       = 256,
	parameter int ROW_W      = 8,
	parameter int CELL_ID    = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrfp_pkg::wr_t                  wr_ctl,
	input  logic [ROW_W-1:0]               wr_row,
	input  logic [VALUE_BITS-1:0]          wr_data,
	input  rrfp_pkg::tok_t                 tok_in,
	input  logic [ROW_W-1:0]               row_in,
	input  logic [rrfp_pkg::IDX_W-1:0]     left,
	input  logic [rrfp_pkg::IDX_W-1:0]     right,
	input  logic [VALUE_BITS-1:0]          target,
	input  logic [rrfp_pkg::LANE_W-1:0]    tgt_lane,
	output rrfp_pkg::tok_t                 tok_out,
	output logic [ROW_W-1:0]               row_out,
	output logic                           fetch_hit,
	output logic [VALUE_BITS-1:0]          fetch_data
);
	import rrfp_pkg::*;

	localparam logic [LANE_W-1:0] LANE = LANE_W'(CELL_ID);

	logic [VALUE_BITS-1:0] mem_q [ROWS];
	logic [VALUE_BITS-1:0] rd_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [ROW_W-1:0]      row_s2;
	tok_t                  tok_s1;
	tok_t                  tok_s2;
	logic [31:0]           elem;
	logic                  in_rng;
	logic                  hit;

	always_ff @(posedge clk) begin
		if (wr_ctl.en && wr_ctl.lane == LANE) begin
			mem_q[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= mem_q[row_in];
		row_s1 <= row_in;
		row_s2 <= row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= '{valid: tok_s1.valid,
			            scan:  tok_s1.scan,
			            last:  tok_s1.last,
			            count: tok_s1.count + CNT_W'(hit)};
		end
	end

	// Global index of the element this cell just read.
	assign elem   = (32'(row_s1) << LANE_W) | 32'(CELL_ID);
	assign in_rng = (elem >= 32'(left)) && (elem <= 32'(right));
	assign hit    = tok_s1.valid && tok_s1.scan && in_rng && (rd_s1 < target);

	assign fetch_hit  = tok_s1.valid && !tok_s1.scan && (tgt_lane == LANE);
	assign fetch_data = rd_s1;
	assign tok_out    = tok_s2;
	assign row_out    = row_s2;

endmodule

// ===== src/rrfp_ctrl.sv =====
module rrfp_ctrl #(
	parameter int DEPTH      = 1024,
	parameter int VALUE_BITS = 16,
	parameter int ROW_W      = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [rrfp_pkg::IDX_W-1:0]     position,
	input  logic [15:0]                    value,
	input  logic [rrfp_pkg::IDX_W-1:0]     range_left,
	input  logic [rrfp_pkg::IDX_W-1:0]     range_right,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           stays_in_place,
	output logic                           bad_query,
	output rrfp_pkg::wr_t                  wr_ctl,
	output logic [ROW_W-1:0]               wr_row,
	output logic [VALUE_BITS-1:0]          wr_data,
	output rrfp_pkg::tok_t                 tok_first,
	output logic [ROW_W-1:0]               row_first,
	output logic [rrfp_pkg::IDX_W-1:0]     left,
	output logic [rrfp_pkg::IDX_W-1:0]     right,
	output logic [VALUE_BITS-1:0]          target,
	output logic [rrfp_pkg::LANE_W-1:0]    tgt_lane,
	input  rrfp_pkg::tok_t                 tok_end,
	input  logic                           fetch_hit [rrfp_pkg::NCELLS],
	input  logic [VALUE_BITS-1:0]          fetch_data [rrfp_pkg::NCELLS]
);
	import rrfp_pkg::*;

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      pos_q, left_q, right_q;
	logic [ROW_W-1:0]      row_q, last_row_q;
	logic [CNT_W-1:0]      acc_q;
	logic                  bad_q;
	logic [VALUE_BITS-1:0] target_q;
	tok_t                  tok_q, tok_d;
	logic [ROW_W-1:0]      tok_row_q, tok_row_d;
	logic                  out_valid_q, stays_q, bad_out_q;
	logic                  accept, is_query, bad_in, any_hit, last_row, out_free;
	logic [VALUE_BITS-1:0] sel_data;

	assign accept   = in_valid && in_ready;
	assign is_query = (mode == MODE_QUERY);
	assign bad_in   = (range_left > position) || (position > range_right) ||
	                  (32'(range_right) >= DEPTH);
	assign last_row = (row_q == last_row_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		any_hit  = 1'b0;
		sel_data = '0;
		for (int i = 0; i < NCELLS; i++) begin
			any_hit = any_hit | fetch_hit[i];
			if (fetch_hit[i]) begin
				sel_data = sel_data | fetch_data[i];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					state_d = bad_in ? ST_DONE : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_FWAIT;
			ST_FWAIT: begin
				if (any_hit) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tok_end.valid && tok_end.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: handshake and the token fed into the first cell.
	always_comb begin
		in_ready  = 1'b0;
		tok_d     = '0;
		tok_row_d = row_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_FETCH: begin
				tok_d.valid = 1'b1;
				tok_row_d   = ROW_W'(32'(pos_q) >> LANE_W);
			end
			ST_SCAN: begin
				tok_d.valid = 1'b1;
				tok_d.scan  = 1'b1;
				tok_d.last  = last_row;
			end
			ST_FWAIT, ST_DRAIN, ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tok_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tok_q   <= tok_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_row_q <= tok_row_d;
		if (accept && is_query) begin
			pos_q      <= position;
			left_q     <= range_left;
			right_q    <= range_right;
			bad_q      <= bad_in;
			row_q      <= ROW_W'(32'(range_left) >> LANE_W);
			last_row_q <= ROW_W'(32'(range_right) >> LANE_W);
			acc_q      <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				row_q <= row_q + ROW_W'(1);
			end
			if (tok_end.valid && tok_end.scan) begin
				acc_q <= acc_q + tok_end.count;
			end
		end
		if (state_q == ST_FWAIT && any_hit) begin
			target_q <= sel_data;
		end
		if (state_q == ST_DONE && out_free) begin
			stays_q   <= !bad_q && (acc_q == CNT_W'(pos_q - left_q));
			bad_out_q <= bad_q;
		end
	end

	assign wr_ctl.en   = accept && !is_query && (32'(position) < DEPTH);
	assign wr_ctl.lane = position[LANE_W-1:0];
	assign wr_row      = ROW_W'(32'(position) >> LANE_W);
	assign wr_data     = VALUE_BITS'(value);

	assign tok_first      = tok_q;
	assign row_first      = tok_row_q;
	assign left           = left_q;
	assign right          = right_q;
	assign target         = target_q;
	assign tgt_lane       = pos_q[LANE_W-1:0];
	assign out_valid      = out_valid_q;
	assign stays_in_place = stays_q;
	assign bad_query      = bad_out_q;

endmodule

// ===== src/range_rank_fixed_point_check_top.sv =====
// A write word is stored at the edge that accepts it; writes are taken back to back.
// A query scans R = right/4 - left/4 + 1 rows (at most 256) of the chain after its fetch;
// a bad query skips the chain and goes straight to ST_DONE. Throughput: one query at a time;
// each cell bank does one read per cycle, so while a query scans a row of NCELLS elements
// enters the chain each cycle. Reset (arst_n low) clears the controller state, the tokens and
// the result valid flag; the element banks are not cleared and hold garbage until written.

// Range rank check.
//
// The element array is interleaved over a chain of identical cells: element k lives in
// cell k % NCELLS, row k / NCELLS. A query first sends a fetch token down the chain to
// read the target value. It then sends one scan token per row covering the range. In
// each cell a token reads that cell's bank, compares the element against the target and
// passes its running count of smaller in-range elements on to the next cell. The
// controller sums the counts of tokens leaving the last cell and compares the total with
// position - range_left.
//
// The result word sits in an output register, so a write word can be accepted while an
// answer waits to be taken.
module range_rank_fixed_point_check_top #(
	parameter int DEPTH      = rrfp_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = rrfp_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [rrfp_pkg::IDX_W-1:0] position,
	input  logic [15:0]                value,
	input  logic [rrfp_pkg::IDX_W-1:0] range_left,
	input  logic [rrfp_pkg::IDX_W-1:0] range_right,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       stays_in_place,
	output logic                       bad_query
);
	import rrfp_pkg::*;

	// Rows per cell bank, rounded up; entries past DEPTH are never written and never counted.
	localparam int ROWS  = (DEPTH + NCELLS - 1) / NCELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	wr_t                   wr_ctl;
	logic [ROW_W-1:0]      wr_row;
	logic [VALUE_BITS-1:0] wr_data;
	tok_t                  tok_w [NCELLS+1];
	logic [ROW_W-1:0]      row_w [NCELLS];
	logic [IDX_W-1:0]      left, right;
	logic [VALUE_BITS-1:0] target;
	logic [LANE_W-1:0]     tgt_lane;
	logic                  fetch_hit [NCELLS];
	logic [VALUE_BITS-1:0] fetch_data [NCELLS];

	rrfp_ctrl #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.ROW_W      (ROW_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.position       (position),
		.value          (value),
		.range_left     (range_left),
		.range_right    (range_right),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.stays_in_place (stays_in_place),
		.bad_query      (bad_query),
		.wr_ctl         (wr_ctl),
		.wr_row         (wr_row),
		.wr_data        (wr_data),
		.tok_first      (tok_w[0]),
		.row_first      (row_w[0]),
		.left           (left),
		.right          (right),
		.target         (target),
		.tgt_lane       (tgt_lane),
		.tok_end        (tok_w[NCELLS]),
		.fetch_hit      (fetch_hit),
		.fetch_data     (fetch_data)
	);

	// The chain of cells. The row of the last cell's token is not needed downstream.
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		if (i < NCELLS - 1) begin : g_mid
			rrfp_cell #(
				.VALUE_BITS (VALUE_BITS),
				.ROWS       (ROWS),
				.ROW_W      (ROW_W),
				.CELL_ID    (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.wr_ctl     (wr_ctl),
				.wr_row     (wr_row),
				.wr_data    (wr_data),
				.tok_in     (tok_w[i]),
				.row_in     (row_w[i]),
				.left       (left),
				.right      (right),
				.target     (target),
				.tgt_lane   (tgt_lane),
				.tok_out    (tok_w[i+1]),
				.row_out    (row_w[i+1]),
				.fetch_hit  (fetch_hit[i]),
				.fetch_data (fetch_data[i])
			);
		end else begin : g_last
			rrfp_cell #(
				.VALUE_BITS (VALUE_BITS),
				.ROWS       (ROWS),
				.ROW_W      (ROW_W),
				.CELL_ID    (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.wr_ctl     (wr_ctl),
				.wr_row     (wr_row),
				.wr_data    (wr_data),
				.tok_in     (tok_w[i]),
				.row_in     (row_w[i]),
				.left       (left),
				.right      (right),
				.target     (target),
				.tgt_lane   (tgt_lane),
				.tok_out    (tok_w[i+1]),
				.row_out    (),
				.fetch_hit  (fetch_hit[i]),
				.fetch_data (fetch_data[i])
			);
		end
	end

endmodule

// ===== src/rrfp_checker.sv =====
module rrfp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic mode,
	input logic out_valid,
	input logic out_ready,
	input logic stays_in_place,
	input logic bad_query
);
	import rrfp_pkg::*;

	// A bad query never claims the target stays in place.
	a_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bad_query && stays_in_place))
		else $error("bad_query and stays_in_place both set");

	// A write word never produces a result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_WRITE) |=> !$rose(out_valid))
		else $error("result appeared after a write word");

	// Once a query is taken the block is busy and takes no further word.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_QUERY) |=> !in_ready)
		else $error("input taken right after a query");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(stays_in_place) && $stable(bad_query)))
		else $error("stalled result word changed");

endmodule

bind range_rank_fixed_point_check_top rrfp_checker u_rrfp_checker (.*);

// ===== tb/range_rank_fixed_point_check_top_test.sv =====
`timescale 1ns / 1ps

// The block keeps an array of element values and answers rank queries over a range of it.
// This bench drives write and query words into the input channel and keeps a shadow copy
// of the element array. For every accepted query it works out the expected answer from
// that shadow copy and queues it. The answers that leave the block are then compared in
// order against that queue.
//
// Entries that were never written hold garbage in the block. For that reason a
// consistent query only ever covers entries that the bench has already written.
// Inconsistent queries read nothing, so a random query that comes out inconsistent keeps its random fields.
module range_rank_fixed_point_check_top_test;
	import rrfp_pkg::*;

	localparam int N_ELEM = DEPTH_DEF;
	localparam int ITEM_TARGET = 580;
	// A cycle in which neither channel moves a word counts toward this limit. The longest
	// legal quiet stretch is the receiver hold-off plus one query, which is far below it.
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	// This is longer than the worst query, so it covers anything still in flight.
	localparam int SETTLE_CYCLES = 300;

	// One expected answer, in the field order of the result ports.
	typedef struct packed {
		logic stays_in_place;
		logic bad_query;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = MODE_WRITE;
	logic [IDX_W-1:0] position = '0;
	logic [15:0]      value = '0;
	logic [IDX_W-1:0] range_left = '0;
	logic [IDX_W-1:0] range_right = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             stays_in_place;
	logic             bad_query;

	// This is the shadow copy of the element array, with a mark for each entry written so far.
	logic [15:0] elem_shadow [N_ELEM];
	bit          written_mask [N_ELEM];

	// These are the answers still owed by the block, oldest first.
	answer_t pending_answers [$];

	int words_sent = 0;
	int fail_count = 0;
	int burst_left = 0;

	// The stimulus raises hold_req to ask the receiver for one long hold-off. The receiver
	// serves the request in its own process.
	int hold_req = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int stall_mode = 0;
	int phase_left = 0;
	int idle_cycles = 0;

	range_rank_fixed_point_check_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.position      (position),
		.value         (value),
		.range_left    (range_left),
		.range_right   (range_right),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stays_in_place(stays_in_place),
		.bad_query     (bad_query)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// This updates the shadow array for a write word. For a query word it queues the answer
	// that the block must give.
	function automatic void predict_rank_answer(input logic m, input logic [IDX_W-1:0] pos,
		input logic [15:0] val, input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
		answer_t ans;
		int      smaller;
		logic [15:0] target;
		if (m == MODE_WRITE) begin
			// A write beyond the array would be dropped. With ten index bits it cannot occur.
			if (pos < N_ELEM) begin
				elem_shadow[pos] = val;
				written_mask[pos] = 1'b1;
			end
			return;
		end
		if (left > pos || pos > right || right >= N_ELEM) begin
			// An inconsistent query is flagged and never counted.
			ans.stays_in_place = 1'b0;
			ans.bad_query = 1'b1;
		end else begin
			// Only strictly smaller values count. Equal values, the target included, do not.
			target = elem_shadow[pos];
			smaller = 0;
			for (int k = left; k <= right; k++) begin
				if (elem_shadow[k] < target)
					smaller++;
			end
			ans.stays_in_place = (smaller == pos - left);
			ans.bad_query = 1'b0;
		end
		pending_answers = {pending_answers, ans};
	endfunction

	// This offers one word and returns at the edge that accepts it. Valid stays high on
	// return, so that a word that follows straight away keeps the channel busy. Anything
	// that waits without sending must call end_burst first.
	task automatic send_word(input logic m, input logic [IDX_W-1:0] pos, input logic [15:0] val,
		input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		position <= pos;
		value <= val;
		range_left <= left;
		range_right <= right;
		// Right after the edge, in_ready still shows the value the block presented at it.
		do
			@(posedge clk);
		while (!in_ready);
		predict_rank_answer(m, pos, val, left, right);
		words_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	// The range fields mean nothing to a write, so they carry random bits.
	task automatic write_elem(input int pos, input logic [15:0] val);
		send_word(MODE_WRITE, IDX_W'(pos), val, IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// The value field means nothing to a query, so it carries random bits.
	task automatic query_rank(input int pos, input int left, input int right);
		send_word(MODE_QUERY, IDX_W'(pos), 16'($urandom), IDX_W'(left), IDX_W'(right));
	endtask

	// This stops sending and waits until every queued answer has come back. At least one
	// edge passes, so valid is never lowered and raised again in the same step.
	task automatic wait_drain();
		end_burst();
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
	endtask

	// Each answer is compared with the oldest one expected.
	function automatic void check_answer();
		answer_t exp_ans;
		if (pending_answers.size() == 0) begin
			$error("answer with no query waiting: stays_in_place=%0b bad_query=%0b",
				stays_in_place, bad_query);
			fail_count++;
		end else begin
			exp_ans = pending_answers.pop_front();
			if (stays_in_place !== exp_ans.stays_in_place) begin
				$error("stays_in_place: expected %0b, actual %0b",
					exp_ans.stays_in_place, stays_in_place);
				fail_count++;
			end
			if (bad_query !== exp_ans.bad_query) begin
				$error("bad_query: expected %0b, actual %0b", exp_ans.bad_query, bad_query);
				fail_count++;
			end
		end
	endfunction

	// This is the receiver. It takes answers under a stall pattern that changes from phase to
	// phase: always ready, mostly ready, or mostly stalled. On request it holds off for one
	// long stretch, so that the block fills up and stops taking words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_answer();
			if (phase_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 200);
			end
			phase_left--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_cnt = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// This is the watchdog. It ends the run when neither channel has moved a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// This stores the extreme values at both ends of the array.
	task automatic test_extreme_writes();
		write_elem(0, 16'h0000);
		write_elem(1, 16'hFFFF);
		write_elem(2, 16'h8000);
		write_elem(1021, 16'h1234);
		write_elem(1022, 16'h0000);
		write_elem(1023, 16'hFFFF);
	endtask

	// These queries put the target at the left end, inside and at the right end of a range,
	// and one query covers a single element.
	task automatic test_target_queries();
		query_rank(0, 0, 2);
		query_rank(1, 0, 2);
		query_rank(1023, 1021, 1023);
		query_rank(1022, 1022, 1022);
	endtask

	// Equal values never count as smaller, so only the first of a run of equals stays in place.
	task automatic test_equal_values();
		for (int k = 16; k < 20; k++)
			write_elem(k, 16'd7);
		write_elem(20, 16'd3);
		query_rank(16, 16, 19);
		query_rank(18, 16, 19);
		query_rank(19, 16, 20);
	endtask

	// These ranges are inconsistent: the left end past the target, or the target past the
	// right end.
	task automatic test_bad_queries();
		query_rank(4, 5, 10);
		query_rank(1023, 0, 1022);
		query_rank(0, 1023, 0);
		query_rank(1023, 1023, 0);
	endtask

	// The receiver holds off while a block of writes and several queries is offered. The
	// answer register fills up, and the input must stall until the hold is over.
	task automatic test_output_backpressure();
		int base;
		base = $urandom_range(0, N_ELEM - 8);
		hold_req++;
		for (int k = 0; k < 8; k++)
			write_elem(base + k, 16'($urandom));
		for (int k = 0; k < 6; k++)
			query_rank(base + $urandom_range(0, 7), base, base + 7);
		wait_drain();
	endtask

	// A wider range of loosely ascending values spans many rows of the cell chain.
	task automatic test_wide_range();
		int base;
		int left;
		int right;
		base = $urandom_range(0, N_ELEM - 96);
		for (int k = 0; k < 96; k++)
			write_elem(base + k, 16'(k * 640 + $urandom_range(0, 900)));
		query_rank(base + $urandom_range(0, 95), base, base + 95);
		query_rank(base, base, base + 95);
		query_rank(base + 95, base, base + 95);
		repeat (3) begin
			left = base + $urandom_range(0, 95);
			right = $urandom_range(left, base + 95);
			query_rank($urandom_range(left, right), left, right);
		end
		wait_drain();
	endtask

	// One well-formed sequence writes a block of elements and then asks a few queries inside
	// it. The value styles are random, few distinct values, ascending and descending. Now and
	// then a query is broken on purpose into an inconsistent one.
	task automatic run_sequence();
		int          len;
		int          base;
		int          style;
		int          left;
		int          right;
		int          pos;
		logic [15:0] v;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		base = $urandom_range(0, N_ELEM - len);
		style = $urandom_range(0, 3);
		for (int k = 0; k < len; k++) begin
			case (style)
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(0, 3));
				2: v = 16'(k * 1300 + $urandom_range(0, 1400));
				default: v = 16'hFFFF - 16'(k * 1300 + $urandom_range(0, 1400));
			endcase
			write_elem(base + k, v);
		end
		repeat ($urandom_range(1, 4)) begin
			left = base + $urandom_range(0, len - 1);
			right = $urandom_range(left, base + len - 1);
			pos = $urandom_range(left, right);
			if ($urandom_range(0, 5) == 0) begin
				if (pos > 0)
					right = $urandom_range(0, pos - 1);
				else
					left = $urandom_range(1, N_ELEM - 1);
			end
			query_rank(pos, left, right);
		end
	endtask

	// A query with fully random fields. If it turns out consistent but reaches entries that
	// were never written, it is turned into an inconsistent one.
	task automatic random_query();
		int left;
		int right;
		int pos;
		bit covered;
		left = $urandom_range(0, N_ELEM - 1);
		right = $urandom_range(0, N_ELEM - 1);
		pos = $urandom_range(0, N_ELEM - 1);
		if (left <= pos && pos <= right) begin
			covered = 1'b1;
			for (int k = left; k <= right; k++)
				covered &= written_mask[k];
			if (!covered) begin
				if (pos > 0)
					right = pos - 1;
				else
					left = 1;
			end
		end
		query_rank(pos, left, right);
	endtask

	// Most traffic is well-formed sequences. The rest is stray writes and random queries.
	task automatic test_random_traffic();
		int sel;
		while (words_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				run_sequence();
			end else if (sel < 17) begin
				repeat ($urandom_range(1, 4))
					write_elem($urandom_range(0, N_ELEM - 1), 16'($urandom));
			end else begin
				random_query();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_writes();
		test_target_queries();
		test_equal_values();
		test_bad_queries();
		wait_drain();
		test_output_backpressure();
		test_wide_range();
		test_random_traffic();
		wait_drain();
		// The bench waits on before it ends, so that a stray answer after the last expected one is caught.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
